// File: rtl/core/assert_macros.svh
// Assertion macros shared by the price level book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/splb_pkg.sv
// Package with shared types and constants of the price level book.
package splb_pkg;
    localparam int DEPTH = 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = 48;
    localparam int OW = 16;
    localparam logic signed [PW-1:0] QMAX = {1'b0, {(PW-1){1'b1}}};

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_ANOMALY = 2'd1;
    localparam logic [1:0] ST_CROSSED = 2'd2;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_BID = 2'd1;

    // Level held in one cell.
    typedef struct packed {
        logic signed [PW-1:0] price;
        logic signed [PW-1:0] qty;
        logic [OW-1:0] orders;
    } level_t;

    // Operation broadcast to every cell of one side.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_UPSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TRADE = 2'd3
    } op_t;

    typedef struct packed {
        op_t op;
        logic asc;
        level_t lvl;
    } cmd_t;

    // Per-cell status reported back to the controller.
    typedef struct packed {
        logic occ;
        logic match;
        logic beat;
    } flag_t;
endpackage

// File: rtl/core/splb_cell.sv
// One level cell: compares the broadcast price and shifts with neighbors.
module splb_cell
    import splb_pkg::*;
(
    input  logic clk,
    input  cmd_t cmd,
    input  logic apply,
    input  logic shift_in,
    input  logic shift_out,
    input  logic write_here,
    input  logic upd_here,
    input  level_t left_lvl,
    input  level_t right_lvl,
    input  logic signed [PW-1:0] new_qty,
    output level_t lvl,
    output logic match,
    output logic beat
);
    level_t lvl_reg;

    // Price compare against the broadcast item.
    assign match = (lvl_reg.price == cmd.lvl.price);
    assign beat = cmd.asc ? (cmd.lvl.price < lvl_reg.price)
                          : (cmd.lvl.price > lvl_reg.price);
    assign lvl = lvl_reg;

    // Insert takes the new level, an update takes the new quantity, a shift takes a neighbor's.
    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            if (write_here)
                lvl_reg <= cmd.lvl;
            else if (upd_here)
            begin
                lvl_reg.qty <= new_qty;
                if (cmd.op == OP_UPSERT)
                    lvl_reg.orders <= cmd.lvl.orders;
            end
            else if (shift_in)
                lvl_reg <= left_lvl;
            else if (shift_out)
                lvl_reg <= right_lvl;
        end
    end
endmodule

// File: rtl/core/splb_side.sv
// One side of the book: a row of level cells and its count.
module splb_side
    import splb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic apply,
    output level_t top,
    output logic [CW-1:0] count,
    output logic gone
);
    level_t lvls [DEPTH];
    logic [DEPTH-1:0] occ, mt, bt, hit, ins_at;
    logic [DEPTH-1:0] sh_in, sh_out, wr, upd;
    logic [CW-1:0] count_reg, count_next;
    logic any_hit, any_ins, full, do_ins, do_rem;
    logic signed [PW:0] tq_wide;
    logic signed [PW-1:0] hit_qty, new_qty;
    logic [DEPTH-1:0] m_raw, b_raw;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            level_t lft, rgt;
            if (g == 0) assign lft = cmd.lvl; else assign lft = lvls[g-1];
            if (g == DEPTH-1) assign rgt = lvls[g]; else assign rgt = lvls[g+1];
            splb_cell u_cell (
                .clk(clk), .cmd(cmd), .apply(apply),
                .shift_in(sh_in[g]), .shift_out(sh_out[g]),
                .write_here(wr[g]), .upd_here(upd[g]),
                .left_lvl(lft), .right_lvl(rgt), .new_qty(new_qty),
                .lvl(lvls[g]), .match(m_raw[g]), .beat(b_raw[g]));
            assign occ[g] = (count_reg > CW'(g));
        end
    endgenerate

    // Matching and insertion point; prices are unique so one hit at most.
    always_comb
    begin
        mt = m_raw & occ;
        bt = b_raw & occ;
        hit = mt;
        any_hit = |mt;
        full = (count_reg == CW'(DEPTH));
        hit_qty = '0;
        for (int i = 0; i < DEPTH; i++)
            if (mt[i]) hit_qty = lvls[i].qty;
        // First beaten cell, or the first empty one.
        ins_at = '0;
        any_ins = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (!any_ins && (bt[i] || !occ[i]))
            begin
                ins_at[i] = 1'b1;
                any_ins = 1'b1;
            end
        tq_wide = {hit_qty[PW-1], hit_qty} - {cmd.lvl.qty[PW-1], cmd.lvl.qty};
        if (tq_wide > (PW+1)'(QMAX))
            new_qty = QMAX;
        else
            new_qty = tq_wide[PW-1:0];
        if (cmd.op == OP_UPSERT)
            new_qty = cmd.lvl.qty;
        do_ins = (cmd.op == OP_UPSERT) && !any_hit && any_ins;
        do_rem = any_hit && ((cmd.op == OP_REMOVE) ||
                 ((cmd.op == OP_TRADE) && (new_qty <= 0)));
        gone = do_rem && apply;
    end

    // Per-cell moves for the chosen operation.
    always_comb
    begin
        logic after_ins, after_hit;
        after_ins = 1'b0;
        after_hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            wr[i] = do_ins && ins_at[i];
            sh_in[i] = do_ins && after_ins && occ[i-0 > 0 ? i-1 : 0];
            if (i == 0) sh_in[i] = 1'b0;
            if (ins_at[i]) after_ins = 1'b1;
            after_hit = after_hit || hit[i];
            sh_out[i] = do_rem && after_hit;
            upd[i] = any_hit && hit[i] && !do_rem &&
                     ((cmd.op == OP_UPSERT) || (cmd.op == OP_TRADE));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins && !full)
            count_next = count_reg + CW'(1);
        else if (do_rem)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (apply)
            count_reg <= count_next;
    end

    assign top = lvls[0];
    assign count = count_reg;

`include "assert_macros.svh"
    `ASSERT_IMP(a_cnt_range, 1'b1, count_reg <= CW'(DEPTH), "level count above depth")
    `ASSERT_IMP(a_one_hit, 1'b1, $onehot0(mt), "price held in two cells")
    `ASSERT_NEXT(a_cnt_hold, !apply, count_reg == $past(count_reg), "count moved while idle")
endmodule

// File: rtl/core/sorted_price_level_book.sv
// Top level of the sorted price level book.
// Usage:
//   An item (level update or trade) is taken on a rising edge with start high
//   and busy low. The fields are registered at that edge; in the next cycle
//   the chosen side's cell row compares the price in every cell at once and
//   shifts, inserts, updates or removes a level at the edge that ends it.
//   The result is on the result ports, marked by done, which is registered
//   from busy and is high for exactly one cycle; it is taken at the edge that
//   ends the done cycle. Busy is high only in the work cycle, so a new item
//   cannot be taken while one is in work, but can be taken at the same edge
//   that takes the previous result. The item rate is set by the input
//   register and the broadcast compare across the cell row.
//   Results cannot be held off by the receiver; each one must be taken in its
//   done cycle.
//   Reset clears both level counts, sets the last time to zero and the last
//   sequence to minus one; cell contents are not cleared, since only cells
//   below the count are ever read.
module sorted_price_level_book
    import splb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic req_type,
    input  logic [1:0] side,
    input  logic signed [47:0] price_ticks,
    input  logic signed [47:0] amount,
    input  logic [15:0] order_total,
    input  logic [62:0] event_time,
    input  logic [46:0] seq_number,
    output logic done,
    output logic [1:0] status,
    output logic best_bid_valid,
    output logic signed [47:0] bid_top_price,
    output logic signed [47:0] bid_top_qty,
    output logic best_ask_valid,
    output logic signed [47:0] ask_top_price,
    output logic signed [47:0] ask_top_qty,
    output logic [4:0] bid_levels,
    output logic [4:0] ask_levels,
    output logic [62:0] last_time,
    output logic signed [47:0] last_seq
);
    logic busy_reg, done_reg;
    logic rt_reg;
    logic [1:0] side_reg;
    level_t in_reg;
    logic [62:0] et_reg, time_reg;
    logic [46:0] sn_reg;
    logic signed [47:0] seq_reg;
    logic [1:0] status_reg;
    logic reject, apply_now, to_bid, gb, ga;
    cmd_t cmd;
    logic bid_apply, ask_apply;
    level_t btop, atop;
    logic [CW-1:0] bcnt, acnt;

    // Decode the held item into a side command.
    always_comb
    begin
        reject = !rt_reg && ((side_reg == SIDE_NONE) ||
                 ((in_reg.qty > 0) && (in_reg.price <= 0)));
        if (rt_reg)
            to_bid = (side_reg != SIDE_BID);
        else
            to_bid = (side_reg == SIDE_BID);
        cmd.lvl = in_reg;
        cmd.asc = !to_bid;
        if (rt_reg)
            cmd.op = OP_TRADE;
        else if (reject)
            cmd.op = OP_NONE;
        else if (in_reg.qty <= 0)
            cmd.op = OP_REMOVE;
        else
            cmd.op = OP_UPSERT;
        apply_now = busy_reg && !reject;
        bid_apply = apply_now && to_bid;
        ask_apply = apply_now && !to_bid;
    end

    splb_side u_bid (.clk(clk), .rst_n(rst_n), .cmd(cmd), .apply(bid_apply),
                     .top(btop), .count(bcnt), .gone(gb));
    splb_side u_ask (.clk(clk), .rst_n(rst_n), .cmd(cmd), .apply(ask_apply),
                     .top(atop), .count(acnt), .gone(ga));

    // Item register.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rt_reg <= req_type;
            side_reg <= side;
            in_reg.price <= price_ticks;
            in_reg.qty <= amount;
            in_reg.orders <= order_total;
            et_reg <= event_time;
            sn_reg <= seq_number;
        end
    end

    // Control, time and sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            time_reg <= '0;
            seq_reg <= '1;
            status_reg <= ST_VALID;
        end
        else
        begin
            done_reg <= busy_reg;
            if (start && !busy_reg)
                busy_reg <= 1'b1;
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
                status_reg <= reject ? ST_ANOMALY : ST_VALID;
                if (!reject)
                    time_reg <= et_reg;
                if (!reject && !rt_reg)
                    seq_reg <= {1'b0, sn_reg};
            end
        end
    end

    // Crossed check on the updated tops, applied updates only.
    logic crossed_ok;
    logic rt_done_reg;
    always_ff @(posedge clk)
    begin
        rt_done_reg <= rt_reg;
    end
    assign crossed_ok = !rt_done_reg && (status_reg == ST_VALID) && (bcnt != '0) &&
                        (acnt != '0) && (btop.price >= atop.price);

    assign busy = busy_reg;
    assign done = done_reg;
    assign status = crossed_ok ? ST_CROSSED : status_reg;
    assign best_bid_valid = (bcnt != '0);
    assign bid_top_price = (bcnt != '0) ? btop.price : '0;
    assign bid_top_qty = (bcnt != '0) ? btop.qty : '0;
    assign best_ask_valid = (acnt != '0);
    assign ask_top_price = (acnt != '0) ? atop.price : '0;
    assign ask_top_qty = (acnt != '0) ? atop.qty : '0;
    assign bid_levels = 5'(bcnt);
    assign ask_levels = 5'(acnt);
    assign last_time = time_reg;
    assign last_seq = seq_reg;

`include "assert_macros.svh"
    `ASSERT_NEXT(a_done_after, busy_reg, done_reg, "result missing after work cycle")
    `ASSERT_IMP(a_one_side, 1'b1, !(bid_apply && ask_apply), "both sides applied")
    `ASSERT_NEXT(a_no_gone_both, gb || ga, done_reg, "removal outside work cycle")
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sorted price level book.
`timescale 1ns / 100ps

// Book predictor and store of expected top-of-book results.
class book_scoreboard;
    typedef struct packed {
        logic [1:0] status;
        logic bid_valid;
        logic signed [47:0] bid_price;
        logic signed [47:0] bid_qty;
        logic ask_valid;
        logic signed [47:0] ask_price;
        logic signed [47:0] ask_qty;
        logic [4:0] bid_lvls;
        logic [4:0] ask_lvls;
        logic [62:0] stamp;
        logic signed [47:0] seq;
    } top_t;

    // Index 0 holds bids, index 1 holds asks.
    longint lv_price[2][splb_pkg::DEPTH];
    longint lv_qty[2][splb_pkg::DEPTH];
    int lv_count[2];
    logic [62:0] cur_time;
    longint cur_seq;
    top_t pending_tops[$];
    int errors;
    int matched;

    function new();
        lv_count[0] = 0;
        lv_count[1] = 0;
        cur_time = '0;
        cur_seq = -1;
        errors = 0;
        matched = 0;
    endfunction

    // True when price a ranks ahead of price b on side s.
    function bit ranks_ahead(int s, longint a, longint b);
        return s == 1 ? a < b : a > b;
    endfunction

    function void drop_at(int s, int k);
        for (int j = k; j + 1 < lv_count[s]; j++)
        begin
            lv_price[s][j] = lv_price[s][j + 1];
            lv_qty[s][j] = lv_qty[s][j + 1];
        end
        lv_count[s]--;
    endfunction

    function int find_level(int s, longint p);
        for (int i = 0; i < lv_count[s]; i++)
            if (lv_price[s][i] == p)
                return i;
        return -1;
    endfunction

    function void upsert(int s, longint p, longint q);
        int k;
        int pos;
        k = find_level(s, p);
        if (k >= 0)
        begin
            lv_qty[s][k] = q;
            return;
        end
        if (lv_count[s] >= splb_pkg::DEPTH)
        begin
            if (!ranks_ahead(s, p, lv_price[s][splb_pkg::DEPTH - 1]))
                return;
            lv_count[s] = splb_pkg::DEPTH - 1;
        end
        pos = lv_count[s];
        for (int i = 0; i < lv_count[s]; i++)
            if (ranks_ahead(s, p, lv_price[s][i]))
            begin
                pos = i;
                break;
            end
        for (int i = lv_count[s]; i > pos; i--)
        begin
            lv_price[s][i] = lv_price[s][i - 1];
            lv_qty[s][i] = lv_qty[s][i - 1];
        end
        lv_price[s][pos] = p;
        lv_qty[s][pos] = q;
        lv_count[s]++;
    endfunction

    // Notes an accepted item and queues the top of book it should give.
    function void note_item(bit is_trade, logic [1:0] sd, logic signed [47:0] price,
                            logic signed [47:0] amt, logic [62:0] stamp, logic [46:0] seq);
        longint p;
        longint a;
        longint q;
        int s;
        int k;
        top_t t;
        p = longint'(price);
        a = longint'(amt);
        t.status = splb_pkg::ST_VALID;
        if (!is_trade)
        begin
            if ((a > 0 && p <= 0) || sd == splb_pkg::SIDE_NONE)
                t.status = splb_pkg::ST_ANOMALY;
            else
            begin
                s = (sd == splb_pkg::SIDE_BID) ? 0 : 1;
                if (a <= 0)
                begin
                    k = find_level(s, p);
                    if (k >= 0)
                        drop_at(s, k);
                end
                else
                    upsert(s, p, a);
                cur_time = stamp;
                cur_seq = longint'(seq);
                if (lv_count[0] > 0 && lv_count[1] > 0 && lv_price[0][0] >= lv_price[1][0])
                    t.status = splb_pkg::ST_CROSSED;
            end
        end
        else
        begin
            // A bid aggressor hits the asks; anything else hits the bids.
            s = (sd == splb_pkg::SIDE_BID) ? 1 : 0;
            k = find_level(s, p);
            if (k >= 0)
            begin
                q = lv_qty[s][k] - a;
                if (q > 64'sd140737488355327)
                    q = 64'sd140737488355327;
                lv_qty[s][k] = q;
                if (q <= 0)
                    drop_at(s, k);
            end
            cur_time = stamp;
        end
        t.bid_valid = lv_count[0] > 0;
        t.bid_price = t.bid_valid ? 48'(lv_price[0][0]) : 48'sd0;
        t.bid_qty = t.bid_valid ? 48'(lv_qty[0][0]) : 48'sd0;
        t.ask_valid = lv_count[1] > 0;
        t.ask_price = t.ask_valid ? 48'(lv_price[1][0]) : 48'sd0;
        t.ask_qty = t.ask_valid ? 48'(lv_qty[1][0]) : 48'sd0;
        t.bid_lvls = 5'(lv_count[0]);
        t.ask_lvls = 5'(lv_count[1]);
        t.stamp = cur_time;
        t.seq = 48'(cur_seq);
        pending_tops.push_back(t);
    endfunction

    // Compares one reported top of book with the oldest expectation.
    function void check_top(top_t got);
        top_t exp_t;
        if (pending_tops.size() == 0)
        begin
            $error("result with no item outstanding");
            errors++;
            return;
        end
        exp_t = pending_tops.pop_front();
        matched++;
        if (got.status !== exp_t.status)
        begin
            $error("status exp %0d got %0d", exp_t.status, got.status); errors++;
        end
        if (got.bid_valid !== exp_t.bid_valid)
        begin
            $error("best_bid_valid exp %0d got %0d", exp_t.bid_valid, got.bid_valid); errors++;
        end
        if (got.bid_price !== exp_t.bid_price)
        begin
            $error("bid_top_price exp %0d got %0d", exp_t.bid_price, got.bid_price); errors++;
        end
        if (got.bid_qty !== exp_t.bid_qty)
        begin
            $error("bid_top_qty exp %0d got %0d", exp_t.bid_qty, got.bid_qty); errors++;
        end
        if (got.ask_valid !== exp_t.ask_valid)
        begin
            $error("best_ask_valid exp %0d got %0d", exp_t.ask_valid, got.ask_valid); errors++;
        end
        if (got.ask_price !== exp_t.ask_price)
        begin
            $error("ask_top_price exp %0d got %0d", exp_t.ask_price, got.ask_price); errors++;
        end
        if (got.ask_qty !== exp_t.ask_qty)
        begin
            $error("ask_top_qty exp %0d got %0d", exp_t.ask_qty, got.ask_qty); errors++;
        end
        if (got.bid_lvls !== exp_t.bid_lvls)
        begin
            $error("bid_levels exp %0d got %0d", exp_t.bid_lvls, got.bid_lvls); errors++;
        end
        if (got.ask_lvls !== exp_t.ask_lvls)
        begin
            $error("ask_levels exp %0d got %0d", exp_t.ask_lvls, got.ask_lvls); errors++;
        end
        if (got.stamp !== exp_t.stamp)
        begin
            $error("last_time exp %0d got %0d", exp_t.stamp, got.stamp); errors++;
        end
        if (got.seq !== exp_t.seq)
        begin
            $error("last_seq exp %0d got %0d", exp_t.seq, got.seq); errors++;
        end
    endfunction
endclass

module tb_top;
    import splb_pkg::*;

    localparam int RAND_ITEMS = 1100;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic req_type = 1'b0;
    logic [1:0] side = '0;
    logic signed [47:0] price_ticks = '0;
    logic signed [47:0] amount = '0;
    logic [15:0] order_total = '0;
    logic [62:0] event_time = '0;
    logic [46:0] seq_number = '0;
    logic done;
    logic [1:0] status;
    logic best_bid_valid;
    logic signed [47:0] bid_top_price;
    logic signed [47:0] bid_top_qty;
    logic best_ask_valid;
    logic signed [47:0] ask_top_price;
    logic signed [47:0] ask_top_qty;
    logic [4:0] bid_levels;
    logic [4:0] ask_levels;
    logic [62:0] last_time;
    logic signed [47:0] last_seq;

    book_scoreboard book;
    int idle_cycles = 0;
    int item_count = 0;
    int trade_count = 0;
    int full_hits = 0;
    bit calm = 1'b0;

    sorted_price_level_book dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results are sampled on the rising edge that ends their cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_top({status, best_bid_valid, bid_top_price, bid_top_qty,
                            best_ask_valid, ask_top_price, ask_top_qty,
                            bid_levels, ask_levels, last_time, last_seq});
    end

    // Watchdog on cycles with nothing accepted.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Drives one item and waits until the block takes it.
    task automatic send_item(bit rt, logic [1:0] sd, logic signed [47:0] p,
                             logic signed [47:0] a, logic [15:0] od);
        if (!calm)
            while ($urandom_range(99) < 26)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        req_type <= rt;
        side <= sd;
        price_ticks <= p;
        amount <= a;
        order_total <= od;
        event_time <= 63'({$urandom, $urandom});
        seq_number <= 47'({$urandom, $urandom});
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_item(rt, side, price_ticks, amount, event_time, seq_number);
        item_count++;
        if (rt)
            trade_count++;
        if (book.lv_count[0] == DEPTH || book.lv_count[1] == DEPTH)
            full_hits++;
        @(negedge clk);
    endtask

    // Random price: mostly a narrow band so levels collide, sometimes anything.
    function automatic logic signed [47:0] pick_price();
        if ($urandom_range(9) == 0)
            return 48'({$urandom, $urandom});
        return 48'sd1000 + 48'($urandom_range(40));
    endfunction

    function automatic logic signed [47:0] pick_amount();
        case ($urandom_range(9))
            0: return -$signed(48'($urandom_range(5)));
            1: return 48'({$urandom, $urandom});
            default: return 48'sd1 + 48'($urandom_range(500));
        endcase
    endfunction

    initial
    begin
        logic [1:0] sd;
        book = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: rejections, extremes, crossing, removal and trades.
        send_item(1'b0, SIDE_NONE, 48'sd100, 48'sd5, 16'hFFFF);
        send_item(1'b0, SIDE_BID, 48'sd0, 48'sd5, 16'd1);
        send_item(1'b0, SIDE_BID, 48'h800000000000, 48'sd5, 16'd1);
        send_item(1'b0, SIDE_BID, 48'sd100, 48'h7FFFFFFFFFFF, 16'hFFFF);
        send_item(1'b0, 2'd3, 48'h7FFFFFFFFFFF, 48'sd7, 16'd0);
        send_item(1'b0, 2'd2, 48'sd90, 48'sd3, 16'd2);
        send_item(1'b0, 2'd2, 48'sd90, 48'sd0, 16'd2);
        send_item(1'b0, 2'd2, 48'sd55, 48'h800000000000, 16'd2);
        send_item(1'b0, 2'd2, 48'h800000000000, 48'sd0, 16'd2);
        send_item(1'b1, SIDE_BID, 48'h7FFFFFFFFFFF, 48'sd3, 16'd0);
        send_item(1'b1, 2'd2, 48'sd100, 48'h800000000000, 16'd0);
        send_item(1'b1, SIDE_NONE, 48'sd100, 48'sd1, 16'd0);
        send_item(1'b1, 2'd3, 48'sd777, 48'sd1, 16'd0);
        send_item(1'b1, 2'd2, 48'sd100, 48'h7FFFFFFFFFFF, 16'd0);
        send_item(1'b1, SIDE_BID, 48'h7FFFFFFFFFFF, 48'sd9, 16'd0);
        // Fill the bids past their depth, then try worse and better prices.
        for (int i = 0; i < DEPTH; i++)
            send_item(1'b0, SIDE_BID, 48'sd200 + 48'(10 * i), 48'sd1, 16'd1);
        send_item(1'b0, SIDE_BID, 48'sd150, 48'sd1, 16'd1);
        send_item(1'b0, SIDE_BID, 48'sd900, 48'sd1, 16'd1);

        // Random part, with one stretch without idling in the middle.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= 400 && n < 550);
            sd = $urandom_range(9) == 0 ? 2'($urandom_range(3)) : 2'(1 + $urandom_range(1));
            if ($urandom_range(99) < 25)
                send_item(1'b1, sd, pick_price(),
                          $urandom_range(19) == 0 ? 48'({$urandom, $urandom})
                                                  : 48'($urandom_range(300)), 16'd0);
            else
                send_item(1'b0, sd, pick_price(), pick_amount(), 16'($urandom));
        end
        calm = 1'b0;
        start <= 1'b0;

        // Drain, then keep watching for anything unexpected.
        while (book.pending_tops.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d items (%0d trades), checked %0d results; a side was full after %0d.",
                 item_count, trade_count, book.matched, full_hits);
        if (book.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
